// ===== rtl/bdll_pkg.sv =====
// Package with the types, codes and constants shared by the linked list block.
`default_nettype none
package bdll_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;
  localparam int IN_W      = 40;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_MATCH = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT,
    S_ALLOC,
    S_LINK,
    S_MATCH,
    S_RM,
    S_DUMP,
    S_RESP
  } state_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_HEAD,
    CUR_TAIL,
    CUR_NEXT,
    CUR_PREV,
    CUR_FREE
  } cur_sel_t;

  typedef struct packed {
    cur_sel_t          cur_sel;
    logic              take;
    logic              alloc;
    logic              front;
    logic              link;
    logic              remove;
    logic              out_load;
    logic              out_dump;
    logic [STAT_W-1:0] out_status;
  } dp_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic out_free;
    logic match;
    logic next_nil;
    logic prev_nil;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/bdll_ram.sv =====
// Generic single write port RAM with one registered read port.
`default_nettype none
module bdll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/bdll_datapath.sv =====
// Datapath of the linked list: node memories, list pointers and result register.
`default_nettype none
module bdll_datapath #(
  parameter int DEPTH = bdll_pkg::DEPTH_DEF,
  localparam int PW = $clog2(DEPTH + 1)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic signed [bdll_pkg::DATA_W-1:0]   value,
  input  wire bdll_pkg::dp_ctrl_t                   ctrl,
  output bdll_pkg::dp_stat_t                        stat,
  input  wire logic                                 out_ready,
  output logic                                      out_valid,
  output logic             [bdll_pkg::STAT_W-1:0]   out_status,
  output logic signed      [bdll_pkg::DATA_W-1:0]   out_data,
  output logic             [PW-1:0]                 out_count,
  output logic                                      out_last
);
  import bdll_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [PW-1:0] NIL = PW'(DEPTH);

  logic [PW-1:0] head, tail, free_head, fill, hwm, cur, aux;
  logic [PW-1:0] cur_next;
  logic signed [DATA_W-1:0] value_q;

  logic [DATA_W-1:0] rd_data;
  logic [PW-1:0]     rd_next, rd_prev, rd_free;

  logic              next_we, prev_we;
  logic [AW-1:0]     next_waddr, prev_waddr;
  logic [PW-1:0]     next_wdata, prev_wdata;

  always_comb begin
    case (ctrl.cur_sel)
      CUR_HOLD: cur_next = cur;
      CUR_HEAD: cur_next = head;
      CUR_TAIL: cur_next = tail;
      CUR_NEXT: cur_next = rd_next;
      CUR_PREV: cur_next = rd_prev;
      CUR_FREE: cur_next = free_head;
      default:  cur_next = cur;
    endcase
  end

  always_comb begin
    next_we    = 1'b0;
    next_waddr = free_head[AW-1:0];
    next_wdata = NIL;
    prev_we    = 1'b0;
    prev_waddr = free_head[AW-1:0];
    prev_wdata = NIL;
    if (ctrl.alloc) begin
      next_we    = 1'b1;
      next_wdata = ctrl.front ? head : NIL;
      prev_we    = 1'b1;
      prev_wdata = ctrl.front ? NIL : tail;
    end else if (ctrl.link) begin
      if (ctrl.front) begin
        prev_we    = (aux != NIL);
        prev_waddr = aux[AW-1:0];
        prev_wdata = cur;
      end else begin
        next_we    = (aux != NIL);
        next_waddr = aux[AW-1:0];
        next_wdata = cur;
      end
    end else if (ctrl.remove) begin
      next_we    = (rd_prev != NIL);
      next_waddr = rd_prev[AW-1:0];
      next_wdata = rd_next;
      prev_we    = (rd_next != NIL);
      prev_waddr = rd_next[AW-1:0];
      prev_wdata = rd_prev;
    end
  end

  bdll_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (ctrl.alloc),
    .waddr (free_head[AW-1:0]),
    .wdata (value_q),
    .raddr (cur_next[AW-1:0]),
    .rdata (rd_data)
  );

  bdll_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (cur_next[AW-1:0]),
    .rdata (rd_next)
  );

  bdll_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (cur_next[AW-1:0]),
    .rdata (rd_prev)
  );

  // Free links are only written when a node is released; nodes at or above the
  // high-water mark have never been used and follow each other in order.
  bdll_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_free_ram (
    .clk   (clk),
    .we    (ctrl.remove),
    .waddr (cur[AW-1:0]),
    .wdata (free_head),
    .raddr (free_head[AW-1:0]),
    .rdata (rd_free)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NIL;
      tail      <= NIL;
      free_head <= '0;
      fill      <= '0;
      hwm       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.alloc) begin
        fill <= PW'(fill + 1'b1);
        if (free_head == hwm) begin
          free_head <= PW'(free_head + 1'b1);
          hwm       <= PW'(hwm + 1'b1);
        end else begin
          free_head <= rd_free;
        end
        if (head == NIL) begin
          head <= free_head;
          tail <= free_head;
        end else if (ctrl.front) begin
          head <= free_head;
        end else begin
          tail <= free_head;
        end
      end else if (ctrl.remove) begin
        fill      <= PW'(fill - 1'b1);
        free_head <= cur;
        if (rd_prev == NIL) begin
          head <= rd_next;
        end
        if (rd_next == NIL) begin
          tail <= rd_prev;
        end
      end
      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (ctrl.take) begin
      value_q <= value;
    end
    if (ctrl.alloc) begin
      aux <= ctrl.front ? head : tail;
    end
    if (ctrl.out_load) begin
      out_status <= ctrl.out_status;
      out_data   <= ctrl.out_dump ? rd_data : '0;
      out_last   <= ctrl.out_dump ? (rd_next == NIL) : 1'b1;
      out_count  <= fill;
    end
  end

  always_comb begin
    stat.full     = (fill == NIL);
    stat.empty    = (head == NIL);
    stat.out_free = !out_valid || out_ready;
    stat.match    = (rd_data == value_q);
    stat.next_nil = (rd_next == NIL);
    stat.prev_nil = (rd_prev == NIL);
  end

endmodule
`default_nettype wire

// ===== rtl/bdll_ctrl.sv =====
// Controller state machine that sequences each list command.
`default_nettype none
module bdll_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [bdll_pkg::CMD_W-1:0]   in_cmd,
  output logic                              in_ready,
  output bdll_pkg::dp_ctrl_t                ctrl,
  input  wire bdll_pkg::dp_stat_t           stat
);
  import bdll_pkg::*;

  state_t            state, state_next;
  logic [CMD_W-1:0]  cmd_q, cmd_q_next;
  logic [STAT_W-1:0] st, st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd_q <= CMD_INS_FRONT;
      st    <= ST_OK;
    end else begin
      state <= state_next;
      cmd_q <= cmd_q_next;
      st    <= st_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_q_next = cmd_q;
    st_next    = st;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_q_next = in_cmd;
          st_next    = ST_OK;
          if (in_cmd inside {CMD_INS_FRONT, CMD_INS_BACK}) begin
            if (stat.full) begin
              st_next    = ST_FULL;
              state_next = S_RESP;
            end else begin
              state_next = S_ALLOC;
            end
          end else if (in_cmd inside {CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_MATCH, CMD_DUMP}) begin
            if (stat.empty) begin
              st_next    = ST_EMPTY;
              state_next = S_RESP;
            end else begin
              state_next = S_WAIT;
            end
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_WAIT: begin
        if (cmd_q inside {CMD_DEL_FRONT, CMD_DEL_BACK}) begin
          state_next = S_RM;
        end else if (cmd_q == CMD_DEL_MATCH) begin
          state_next = S_MATCH;
        end else if (cmd_q == CMD_DUMP) begin
          state_next = S_DUMP;
        end else begin
          state_next = S_RESP;
        end
      end
      S_ALLOC: state_next = S_LINK;
      S_LINK:  state_next = S_RESP;
      S_MATCH: begin
        if (stat.match) begin
          state_next = S_RM;
        end else if (stat.prev_nil) begin
          st_next    = ST_NOMATCH;
          state_next = S_RESP;
        end
      end
      S_RM: state_next = S_RESP;
      S_DUMP: begin
        if (stat.out_free && stat.next_nil) begin
          state_next = S_IDLE;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    ctrl            = '0;
    ctrl.cur_sel    = CUR_HOLD;
    ctrl.out_status = st;
    ctrl.front      = (cmd_q == CMD_INS_FRONT);
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        ctrl.take = in_valid;
        if (in_valid) begin
          if (in_cmd inside {CMD_DEL_FRONT, CMD_DUMP}) begin
            ctrl.cur_sel = CUR_HEAD;
          end else if (in_cmd inside {CMD_DEL_BACK, CMD_DEL_MATCH}) begin
            ctrl.cur_sel = CUR_TAIL;
          end
        end
      end
      S_ALLOC: begin
        ctrl.alloc   = 1'b1;
        ctrl.cur_sel = CUR_FREE;
      end
      S_LINK: ctrl.link = 1'b1;
      S_MATCH: begin
        if (!stat.match && !stat.prev_nil) begin
          ctrl.cur_sel = CUR_PREV;
        end
      end
      S_RM: ctrl.remove = 1'b1;
      S_DUMP: begin
        if (stat.out_free) begin
          ctrl.out_load   = 1'b1;
          ctrl.out_dump   = 1'b1;
          ctrl.out_status = ST_OK;
          if (!stat.next_nil) begin
            ctrl.cur_sel = CUR_NEXT;
          end
        end
      end
      S_RESP: ctrl.out_load = stat.out_free;
      default: ctrl.cur_sel = CUR_HOLD;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/bounded_doubly_linked_list_top.sv =====
// Top level of the bounded doubly linked list of signed 32-bit values.
// The block keeps up to DEPTH values in node memories with next and prev links and takes
// one command transaction at a time: insert front or back, delete front or back, delete
// the last node that matches a value, or dump the list from head to tail. An insert
// passes through allocate, link and response states; a front or back delete waits for
// the node read, removes the node and responds. Delete by match walks back from the tail
// until a node matches and is removed, or answers no match when it reaches the head.
// A dump gives one value per cycle from head to tail while the output register is free.
// The one read port of each node memory, walked one link per cycle, bounds how fast a
// command that walks the list completes. A result waits in an output register and the
// next command is accepted in the cycle after the last result is loaded. No clearing pass
// is needed after reset. Status travels in m_tuser, and tlast marks the final result of
// each command.
`default_nettype none
module bounded_doubly_linked_list_top #(
  parameter int DEPTH = bdll_pkg::DEPTH_DEF,
  localparam int PW = $clog2(DEPTH + 1),
  localparam int MW = ((bdll_pkg::DATA_W + PW + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [bdll_pkg::IN_W-1:0]       s_tdata,  // cmd[2:0], value[34:3]
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [MW-1:0]                   m_tdata,  // data[31:0], count above it
  output logic      [bdll_pkg::STAT_W-1:0]     m_tuser,  // status[1:0]
  output logic                                 m_tlast
);
  import bdll_pkg::*;

  dp_ctrl_t                 ctrl;
  dp_stat_t                 stat;
  logic signed [DATA_W-1:0] out_data;
  logic        [PW-1:0]     out_count;

  bdll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (s_tdata[CMD_W-1:0]),
    .in_ready (s_tready),
    .ctrl     (ctrl),
    .stat     (stat)
  );

  bdll_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .value      (s_tdata[CMD_W+DATA_W-1:CMD_W]),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_status (m_tuser),
    .out_data   (out_data),
    .out_count  (out_count),
    .out_last   (m_tlast)
  );

  assign m_tdata = MW'({out_count, out_data});

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a command was still in progress");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> m_tlast)
    else $error("error result without last mark");

  a_error_data_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (out_data == '0))
    else $error("error result carries nonzero data");

endmodule
`default_nettype wire
